// File: rtl/sta_lta_onset_gate_macros.svh
// ---------------------------------------------------------------------------
// sta_lta_onset_gate assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef STA_LTA_ONSET_GATE_MACROS_SVH
`define STA_LTA_ONSET_GATE_MACROS_SVH

// Same-cycle implication
`define SLG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define SLG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/sta_lta_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sta_lta_pkg
// Types, codes and constants of the STA/LTA onset gate.
// ---------------------------------------------------------------------------
package sta_lta_pkg;

	localparam int CHANNELS_DEF = 64;
	localparam int CH_W         = 6;
	localparam int ALPHA_W      = 17;
	localparam int CNT_W        = 16;
	localparam int SUM_W        = 48;
	localparam int DIV_NUM_W    = 49;
	localparam int DIV_DEN_W    = 32;

	localparam logic [ALPHA_W-1:0] ONE_Q16 = 17'd65536;
	localparam logic [31:0]        ONE_RATIO = 32'd65536;

	localparam logic [2:0] KIND_OVERLOAD = 3'd5;
	localparam logic [1:0] WARN_CRITICAL = 2'd2;

	typedef enum logic [2:0] {
		CFG_STA_ALPHA     = 3'd0,
		CFG_LTA_ALPHA     = 3'd1,
		CFG_ON_RATIO      = 3'd2,
		CFG_OFF_RATIO     = 3'd3,
		CFG_CALIB_WINDOWS = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_STA_MUL,
		ST_STA_ADD,
		ST_LTA_MUL,
		ST_LTA_ADD,
		ST_RATIO_GO,
		ST_RATIO_WAIT,
		ST_ON_MUL,
		ST_ON_CMP,
		ST_OFF_CMP,
		ST_DECIDE,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		MEAN_RMS,
		MEAN_ENERGY,
		MEAN_FREQ
	} mean_sel_t;

	// Per-channel record held in the state memory
	typedef struct packed {
		logic [31:0]       short_avg;
		logic [31:0]       long_avg;
		logic              primed;
		logic              trig;
		logic              learned;
		logic [CNT_W-1:0]  window_count;
		logic [SUM_W-1:0]  sum_rms;
		logic [SUM_W-1:0]  sum_energy;
		logic [SUM_W-1:0]  sum_freq;
		logic [31:0]       mean_rms;
		logic [31:0]       mean_energy;
		logic [31:0]       mean_freq;
	} rec_t;

	// Divider status seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Fold a channel number onto n slots without a divider
	function automatic int slot_of(input int ch, input int n);
		int k;
		k = 0;
		for (int i = 0; i < ch; i++) begin
			k = (k == n - 1) ? 0 : k + 1;
		end
		return k;
	endfunction

endpackage

// File: rtl/sta_lta_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sta_lta_div
// Restoring divider, one quotient bit per cycle, 32-bit saturated quotient.
// ---------------------------------------------------------------------------
module sta_lta_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [sta_lta_pkg::DIV_NUM_W-1:0]   num,
	input  logic [sta_lta_pkg::DIV_DEN_W-1:0]   den,
	output sta_lta_pkg::div_stat_t              stat,
	output logic [31:0]                         quo
);

	localparam int NW  = sta_lta_pkg::DIV_NUM_W;
	localparam int DW  = sta_lta_pkg::DIV_DEN_W;
	localparam int CW  = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic          den_zero_q;

	logic [DW:0]   shifted;
	logic [DW:0]   diff;
	logic          ge;

	// Trial subtract of the shifted remainder
	always_comb begin
		shifted = {rem_q, num_q[NW-1]};
		diff    = shifted - {1'b0, den_q};
		ge      = (shifted >= {1'b0, den_q});
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: quotient bits shift in behind the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			num_q      <= num;
			den_q      <= den;
			rem_q      <= '0;
			den_zero_q <= (den == '0);
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
			num_q <= {num_q[NW-2:0], ge};
		end
	end

	// Saturate to 32 bits; a zero divisor yields zero
	always_comb begin
		if (den_zero_q) begin
			quo = '0;
		end else if (num_q[NW-1:32] != '0) begin
			quo = '1;
		end else begin
			quo = num_q[31:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: rtl/sta_lta_onset_gate.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sta_lta_onset_gate
// Per-channel STA/LTA trigger with hysteresis and a learned baseline.
// ---------------------------------------------------------------------------
//  channel | signals                        | handshake
//  --------+--------------------------------+------------------------------
//  in      | channel .. health_in           | in_valid / in_stall
//  out     | channel_out .. baseline_valid  | out_valid / out_stall
//  cfg     | cfg_index, cfg_data            | cfg_valid / cfg_ready
//
//  An item passes the STA smoothing multiply, the LTA smoothing multiply
//  unless the channel was triggered, the ratio division unless the long
//  average is zero, and two compare multiplies; the window that completes
//  calibration adds three mean divisions. After reset, with in_stall high,
//  a pass zeroes the state memory. A stalled result word waits in the
//  output register while the next item is taken in.
// ---------------------------------------------------------------------------
`include "sta_lta_onset_gate_macros.svh"

module sta_lta_onset_gate #(
	parameter int CHANNELS = sta_lta_pkg::CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [5:0]  channel,
	input  logic [31:0] rms_value,
	input  logic [31:0] energy_value,
	input  logic [31:0] freq_value,
	input  logic        anomaly_in,
	input  logic [2:0]  anomaly_kind_in,
	input  logic [1:0]  warning_in,
	input  logic [16:0] health_in,
	// result words
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  channel_out,
	output logic        anomaly_out,
	output logic [2:0]  anomaly_kind_out,
	output logic [1:0]  warning_out,
	output logic [16:0] health_out,
	output logic [31:0] sta_lta_ratio,
	output logic        triggered_out,
	output logic        calibrating,
	output logic [31:0] baseline_rms,
	output logic [31:0] baseline_energy,
	output logic [31:0] baseline_freq,
	output logic        baseline_valid,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int NCH_IN = 2 ** sta_lta_pkg::CH_W;
	localparam int CW     = sta_lta_pkg::CNT_W;
	localparam int SW     = sta_lta_pkg::SUM_W;

	// Configuration registers
	logic [16:0] sta_alpha_q;
	logic [16:0] lta_alpha_q;
	logic [31:0] on_ratio_q;
	logic [31:0] off_ratio_q;
	logic [15:0] calib_q;
	logic [16:0] cfg_alpha;

	// Sequencer
	sta_lta_pkg::state_t state_q, state_d;
	logic [AW-1:0]       clr_cnt_q;

	// State memory
	sta_lta_pkg::rec_t mem [CHANNELS];
	sta_lta_pkg::rec_t rd_q;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	sta_lta_pkg::rec_t mem_wd;

	// Slot lookup
	logic [AW-1:0] slot_tbl [NCH_IN];
	logic [AW-1:0] slot_q;

	// Latched input word
	logic [5:0]  ch_q;
	logic [31:0] rms_q;
	logic [31:0] energy_q;
	logic [31:0] freq_q;
	logic        anom_q;
	logic [2:0]  kind_q;
	logic [1:0]  warn_q;
	logic [16:0] health_q;

	// Working record and results
	sta_lta_pkg::rec_t     rec_q;
	sta_lta_pkg::rec_t     rec_ld;
	logic                  trig_old_q;
	logic                  learned_old_q;
	logic [63:0]           prod_q;
	logic                  neg_q;
	logic [31:0]           ratio_q;
	logic                  above_q;
	logic                  below_q;
	sta_lta_pkg::mean_sel_t mean_sel_q;

	// Gated verdict
	logic        gate_anom;
	logic [2:0]  gate_kind;
	logic [1:0]  gate_warn;
	logic [16:0] gate_health;

	// Output register
	logic out_valid_q;
	logic out_free;

	// Arithmetic
	logic [31:0]  mul_a;
	logic [31:0]  mul_b;
	logic [63:0]  mul_p;
	logic [31:0]  sm_base;
	logic [31:0]  sm_mag;
	logic [32:0]  sm_step;
	logic [31:0]  sm_res;
	logic [63:0]  num64;
	logic         lta_zero;
	logic [CW-1:0] cnt_next;
	logic         complete;
	logic         trig_new;

	// Divider
	logic                               div_start;
	logic [sta_lta_pkg::DIV_NUM_W-1:0]  div_num;
	logic [sta_lta_pkg::DIV_DEN_W-1:0]  div_den;
	sta_lta_pkg::div_stat_t             div_stat;
	logic [31:0]                        div_quo;
	logic [SW-1:0]                      mean_sum;

	logic in_acc;

	// Fold channel numbers onto state slots
	for (genvar gi = 0; gi < NCH_IN; gi++) begin : g_slot
		assign slot_tbl[gi] = AW'(sta_lta_pkg::slot_of(gi, CHANNELS));
	end

	assign in_stall  = (state_q != sta_lta_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// Configuration writes; alpha saturates at 1.0
	assign cfg_alpha = (cfg_data[16:0] > sta_lta_pkg::ONE_Q16) ? sta_lta_pkg::ONE_Q16
		: cfg_data[16:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sta_alpha_q <= 17'd6554;
			lta_alpha_q <= 17'd655;
			on_ratio_q  <= 32'd196608;
			off_ratio_q <= 32'd98304;
			calib_q     <= 16'd10;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sta_lta_pkg::CFG_STA_ALPHA:     sta_alpha_q <= cfg_alpha;
				sta_lta_pkg::CFG_LTA_ALPHA:     lta_alpha_q <= cfg_alpha;
				sta_lta_pkg::CFG_ON_RATIO:      on_ratio_q  <= cfg_data;
				sta_lta_pkg::CFG_OFF_RATIO:     off_ratio_q <= cfg_data;
				sta_lta_pkg::CFG_CALIB_WINDOWS: calib_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Shared multiplier operands
	always_comb begin
		sm_base = (state_q == sta_lta_pkg::ST_STA_MUL || state_q == sta_lta_pkg::ST_STA_ADD)
			? rec_q.short_avg : rec_q.long_avg;
		sm_mag  = (rms_q < sm_base) ? (sm_base - rms_q) : (rms_q - sm_base);
		mul_a   = '0;
		mul_b   = '0;
		case (state_q)
			sta_lta_pkg::ST_STA_MUL: begin
				mul_a = sm_mag;
				mul_b = {15'd0, sta_alpha_q};
			end
			sta_lta_pkg::ST_LTA_MUL: begin
				mul_a = sm_mag;
				mul_b = {15'd0, lta_alpha_q};
			end
			sta_lta_pkg::ST_ON_MUL: begin
				mul_a = on_ratio_q;
				mul_b = rec_q.long_avg;
			end
			sta_lta_pkg::ST_ON_CMP: begin
				mul_a = off_ratio_q;
				mul_b = rec_q.long_avg;
			end
			default: ;
		endcase
		mul_p = mul_a * mul_b;
	end

	// Rounded smoothing step, ties away from zero
	always_comb begin
		sm_step = 33'((prod_q + 64'd32768) >> 16);
		sm_res  = neg_q ? 32'({1'b0, sm_base} - sm_step) : 32'({1'b0, sm_base} + sm_step);
	end

	// Ratio numerator, trigger decision and calibration window count
	always_comb begin
		num64    = {16'd0, rec_q.short_avg, 16'd0};
		lta_zero = (rec_q.long_avg == '0);
		trig_new = trig_old_q ? !below_q : above_q;
		cnt_next = rec_q.window_count + 1'b1;
		complete = ({16'd0, cnt_next} >= {16'd0, calib_q});
	end

	// Prime both averages on a channel's first word
	always_comb begin
		rec_ld = rd_q;
		if (!rd_q.primed) begin
			rec_ld.short_avg = rms_q;
			rec_ld.long_avg  = rms_q;
			rec_ld.primed    = 1'b1;
		end
	end

	// Divider operands
	always_comb begin
		case (mean_sel_q)
			sta_lta_pkg::MEAN_RMS:    mean_sum = rec_q.sum_rms;
			sta_lta_pkg::MEAN_ENERGY: mean_sum = rec_q.sum_energy;
			sta_lta_pkg::MEAN_FREQ:   mean_sum = rec_q.sum_freq;
			default:                  mean_sum = '0;
		endcase
		div_start = (state_q == sta_lta_pkg::ST_RATIO_GO && !lta_zero)
			|| (state_q == sta_lta_pkg::ST_MEAN_GO);
		if (state_q == sta_lta_pkg::ST_MEAN_GO) begin
			div_num = {1'b0, mean_sum} + {{(SW + 1 - CW){1'b0}}, (rec_q.window_count >> 1)};
			div_den = {16'd0, rec_q.window_count};
		end else begin
			div_num = {1'b0, num64[47:0]};
			div_den = rec_q.long_avg;
		end
	end

	sta_lta_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sta_lta_pkg::ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == sta_lta_pkg::ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	// Next state and memory write
	always_comb begin
		state_d = state_q;
		mem_we  = 1'b0;
		mem_wa  = slot_q;
		mem_wd  = rec_q;
		unique case (state_q)
			sta_lta_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_cnt_q;
				mem_wd = '0;
				if (clr_cnt_q == AW'(CHANNELS - 1)) begin
					state_d = sta_lta_pkg::ST_IDLE;
				end
			end
			sta_lta_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = sta_lta_pkg::ST_LOAD;
				end
			end
			sta_lta_pkg::ST_LOAD:    state_d = sta_lta_pkg::ST_STA_MUL;
			sta_lta_pkg::ST_STA_MUL: state_d = sta_lta_pkg::ST_STA_ADD;
			sta_lta_pkg::ST_STA_ADD: begin
				state_d = trig_old_q ? sta_lta_pkg::ST_RATIO_GO : sta_lta_pkg::ST_LTA_MUL;
			end
			sta_lta_pkg::ST_LTA_MUL: state_d = sta_lta_pkg::ST_LTA_ADD;
			sta_lta_pkg::ST_LTA_ADD: state_d = sta_lta_pkg::ST_RATIO_GO;
			sta_lta_pkg::ST_RATIO_GO: begin
				state_d = lta_zero ? sta_lta_pkg::ST_ON_MUL : sta_lta_pkg::ST_RATIO_WAIT;
			end
			sta_lta_pkg::ST_RATIO_WAIT: begin
				if (div_stat.done) begin
					state_d = sta_lta_pkg::ST_ON_MUL;
				end
			end
			sta_lta_pkg::ST_ON_MUL:  state_d = sta_lta_pkg::ST_ON_CMP;
			sta_lta_pkg::ST_ON_CMP:  state_d = sta_lta_pkg::ST_OFF_CMP;
			sta_lta_pkg::ST_OFF_CMP: state_d = sta_lta_pkg::ST_DECIDE;
			sta_lta_pkg::ST_DECIDE: begin
				state_d = (!learned_old_q && complete) ? sta_lta_pkg::ST_MEAN_GO
					: sta_lta_pkg::ST_FINISH;
			end
			sta_lta_pkg::ST_MEAN_GO: state_d = sta_lta_pkg::ST_MEAN_WAIT;
			sta_lta_pkg::ST_MEAN_WAIT: begin
				if (div_stat.done) begin
					state_d = (mean_sel_q == sta_lta_pkg::MEAN_FREQ) ? sta_lta_pkg::ST_FINISH
						: sta_lta_pkg::ST_MEAN_GO;
				end
			end
			sta_lta_pkg::ST_FINISH: begin
				if (out_free) begin
					mem_we  = 1'b1;
					state_d = sta_lta_pkg::ST_IDLE;
				end
			end
			default: state_d = sta_lta_pkg::ST_IDLE;
		endcase
	end

	// Memory: one write port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (in_acc) begin
			rd_q <= mem[slot_tbl[channel]];
		end
	end

	// Working datapath
	always_ff @(posedge clk) begin
		case (state_q)
			sta_lta_pkg::ST_IDLE: begin
				if (in_acc) begin
					slot_q   <= slot_tbl[channel];
					ch_q     <= channel;
					rms_q    <= rms_value;
					energy_q <= energy_value;
					freq_q   <= freq_value;
					anom_q   <= anomaly_in;
					kind_q   <= anomaly_kind_in;
					warn_q   <= warning_in;
					health_q <= (health_in > sta_lta_pkg::ONE_Q16) ? sta_lta_pkg::ONE_Q16
						: health_in;
				end
			end
			sta_lta_pkg::ST_LOAD: begin
				rec_q         <= rec_ld;
				trig_old_q    <= rd_q.trig;
				learned_old_q <= rd_q.learned;
			end
			sta_lta_pkg::ST_STA_MUL, sta_lta_pkg::ST_LTA_MUL: begin
				prod_q <= mul_p;
				neg_q  <= (rms_q < sm_base);
			end
			sta_lta_pkg::ST_STA_ADD: rec_q.short_avg <= sm_res;
			sta_lta_pkg::ST_LTA_ADD: rec_q.long_avg  <= sm_res;
			sta_lta_pkg::ST_RATIO_GO: begin
				ratio_q <= sta_lta_pkg::ONE_RATIO;
			end
			sta_lta_pkg::ST_RATIO_WAIT: begin
				if (div_stat.done) begin
					ratio_q <= div_quo;
				end
			end
			sta_lta_pkg::ST_ON_MUL: prod_q <= mul_p;
			sta_lta_pkg::ST_ON_CMP: begin
				above_q <= lta_zero ? ({15'd0, sta_lta_pkg::ONE_Q16} > on_ratio_q)
					: (num64 > prod_q);
				prod_q  <= mul_p;
			end
			sta_lta_pkg::ST_OFF_CMP: begin
				below_q <= lta_zero ? ({15'd0, sta_lta_pkg::ONE_Q16} < off_ratio_q)
					: (num64 < prod_q);
			end
			sta_lta_pkg::ST_DECIDE: begin
				mean_sel_q <= sta_lta_pkg::MEAN_RMS;
				rec_q.trig <= learned_old_q ? trig_new : 1'b0;
				// accumulate the baseline while calibrating
				if (!learned_old_q) begin
					rec_q.sum_rms      <= rec_q.sum_rms + {16'd0, rms_q};
					rec_q.sum_energy   <= rec_q.sum_energy + {16'd0, energy_q};
					rec_q.sum_freq     <= rec_q.sum_freq + {16'd0, freq_q};
					rec_q.window_count <= cnt_next;
					if (complete) begin
						rec_q.learned <= 1'b1;
					end
				end
			end
			sta_lta_pkg::ST_MEAN_WAIT: begin
				if (div_stat.done) begin
					case (mean_sel_q)
						sta_lta_pkg::MEAN_RMS: begin
							rec_q.mean_rms <= div_quo;
							mean_sel_q     <= sta_lta_pkg::MEAN_ENERGY;
						end
						sta_lta_pkg::MEAN_ENERGY: begin
							rec_q.mean_energy <= div_quo;
							mean_sel_q        <= sta_lta_pkg::MEAN_FREQ;
						end
						default: rec_q.mean_freq <= div_quo;
					endcase
				end
			end
			default: ;
		endcase
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == sta_lta_pkg::ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Verdict gating: force normal while calibrating, drop an unconfirmed
	// anomaly unless it is a critical overload
	always_comb begin
		gate_anom   = anom_q;
		gate_kind   = kind_q;
		gate_warn   = warn_q;
		gate_health = health_q;
		if (!learned_old_q) begin
			gate_anom   = 1'b0;
			gate_kind   = '0;
			gate_warn   = '0;
			gate_health = sta_lta_pkg::ONE_Q16;
		end else if (anom_q && !rec_q.trig && !(warn_q == sta_lta_pkg::WARN_CRITICAL
				&& kind_q == sta_lta_pkg::KIND_OVERLOAD)) begin
			gate_anom = 1'b0;
			gate_kind = '0;
			gate_warn = '0;
		end
	end

	// Output word
	always_ff @(posedge clk) begin
		if (state_q == sta_lta_pkg::ST_FINISH && out_free) begin
			channel_out      <= ch_q;
			sta_lta_ratio    <= ratio_q;
			triggered_out    <= rec_q.trig;
			calibrating      <= !learned_old_q;
			baseline_rms     <= rec_q.mean_rms;
			baseline_energy  <= rec_q.mean_energy;
			baseline_freq    <= rec_q.mean_freq;
			baseline_valid   <= rec_q.learned;
			anomaly_out      <= gate_anom;
			anomaly_kind_out <= gate_kind;
			warning_out      <= gate_warn;
			health_out       <= gate_health;
		end
	end

	`SLG_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted word did not start work")
	`SLG_ASSERT_IMP(a_no_accept_clear, state_q == sta_lta_pkg::ST_CLEAR, in_stall, "word taken during clearing pass")
	`SLG_ASSERT_IMP(a_div_start_idle, div_start, !div_stat.busy, "divider restarted while busy")
	`SLG_ASSERT_NXT(a_finish_loads, state_q == sta_lta_pkg::ST_FINISH && !out_valid_q, out_valid_q, "finished word not presented")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: STA/LTA onset gate testbench
// Drives window features through the gate under changing register settings,
// with random idling on both channels, and checks every result word against
// a cycle-free model of trigger, calibration and gating, or a row's typed result.
// ---------------------------------------------------------------------------
module tb;

	typedef struct {
		bit [5:0]  ch;
		bit [31:0] rms;
		bit [31:0] energy;
		bit [31:0] freq;
		bit        anom;
		bit [2:0]  kind;
		bit [1:0]  warn;
		bit [16:0] health;
	} gate_item_t;

	typedef struct {
		bit [5:0]  ch;
		bit        anom;
		bit [2:0]  kind;
		bit [1:0]  warn;
		bit [16:0] health;
		bit [31:0] ratio;
		bit        trig;
		bit        calib;
		bit [31:0] b_rms;
		bit [31:0] b_energy;
		bit [31:0] b_freq;
		bit        b_valid;
	} gate_res_t;

	typedef struct {
		gate_item_t it;
		bit         typed;
		gate_res_t  want;
	} stim_row_t;

	typedef bit [63:0] fld_arr_t [12];

	localparam int NCH = 64;
	localparam int SETTLE = 300;
	localparam int PHASE_ITEMS = 125;
	localparam int PEND_DEPTH = 1024;

	bit clk;
	logic arst_n;
	logic in_valid, in_stall;
	logic [5:0] channel;
	logic [31:0] rms_value, energy_value, freq_value;
	logic anomaly_in;
	logic [2:0] anomaly_kind_in;
	logic [1:0] warning_in;
	logic [16:0] health_in;
	logic out_valid, out_stall;
	logic [5:0] channel_out;
	logic anomaly_out;
	logic [2:0] anomaly_kind_out;
	logic [1:0] warning_out;
	logic [16:0] health_out;
	logic [31:0] sta_lta_ratio;
	logic triggered_out, calibrating;
	logic [31:0] baseline_rms, baseline_energy, baseline_freq;
	logic baseline_valid;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	sta_lta_onset_gate dut (.*);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// model registers and per-channel state
	bit [16:0] sta_alpha_m, lta_alpha_m;
	bit [31:0] on_m, off_m;
	bit [15:0] calib_m;
	bit [31:0] sta_m [NCH], lta_m [NCH];
	bit primed_m [NCH], trig_m [NCH], learned_m [NCH];
	bit [15:0] count_m [NCH];
	bit [47:0] sum_rms_m [NCH], sum_energy_m [NCH], sum_freq_m [NCH];
	bit [31:0] mean_rms_m [NCH], mean_energy_m [NCH], mean_freq_m [NCH];
	bit [31:0] level [8];

	// expected words in order, written at pend_wr and read at pend_rd
	gate_res_t pending_verdicts [PEND_DEPTH];
	int pend_wr, pend_rd;
	int errors, items_sent, words_checked, trig_seen, learned_seen;
	bit quiet;
	int stall_left;

	string fld_name [12] = '{"channel_out", "anomaly_out", "anomaly_kind_out",
		"warning_out", "health_out", "sta_lta_ratio", "triggered_out", "calibrating",
		"baseline_rms", "baseline_energy", "baseline_freq", "baseline_valid"};

	// exponential smoothing, rounded to nearest with ties away from zero
	function automatic bit [31:0] ema(bit [31:0] x, bit [31:0] cf, bit [16:0] a);
		bit [63:0] step;
		if (cf >= x) begin
			step = (64'(cf - x) * 64'(a) + 64'd32768) >> 16;
			return x + step[31:0];
		end
		step = (64'(x - cf) * 64'(a) + 64'd32768) >> 16;
		return x - step[31:0];
	endfunction

	function automatic bit [31:0] avg(bit [47:0] s, bit [15:0] n);
		bit [63:0] q;
		if (n == 0)
			return 0;
		q = (64'(s) + 64'(n / 2)) / 64'(n);
		return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
	endfunction

	// advance one channel and return the gated verdict
	function automatic gate_res_t gate_predict(gate_item_t it);
		gate_res_t r;
		bit [5:0] c;
		bit [31:0] sta, lta, ratio;
		bit [63:0] num, q;
		bit trig, above, below;
		c = it.ch;
		r.ch = it.ch;
		r.anom = it.anom;
		r.kind = it.kind;
		r.warn = it.warn;
		r.health = (it.health > sta_lta_pkg::ONE_Q16) ? sta_lta_pkg::ONE_Q16 : it.health;
		r.calib = 1'b0;
		if (!primed_m[c]) begin
			sta_m[c] = it.rms;
			lta_m[c] = it.rms;
			primed_m[c] = 1'b1;
		end
		trig = trig_m[c];
		sta_m[c] = ema(sta_m[c], it.rms, sta_alpha_m);
		if (!trig)
			lta_m[c] = ema(lta_m[c], it.rms, lta_alpha_m);
		sta = sta_m[c];
		lta = lta_m[c];
		if (lta == 0) begin
			ratio = sta_lta_pkg::ONE_RATIO;
			above = sta_lta_pkg::ONE_RATIO > on_m;
			below = sta_lta_pkg::ONE_RATIO < off_m;
		end else begin
			num = 64'(sta) << 16;
			q = num / 64'(lta);
			ratio = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
			above = num > 64'(on_m) * 64'(lta);
			below = num < 64'(off_m) * 64'(lta);
		end
		// hysteresis
		if (trig) begin
			if (below)
				trig = 1'b0;
		end else if (above) begin
			trig = 1'b1;
		end
		if (!learned_m[c]) begin
			r.calib = 1'b1;
			sum_rms_m[c] = sum_rms_m[c] + 48'(it.rms);
			sum_energy_m[c] = sum_energy_m[c] + 48'(it.energy);
			sum_freq_m[c] = sum_freq_m[c] + 48'(it.freq);
			count_m[c] = count_m[c] + 16'd1;
			if (count_m[c] >= calib_m) begin
				mean_rms_m[c] = avg(sum_rms_m[c], count_m[c]);
				mean_energy_m[c] = avg(sum_energy_m[c], count_m[c]);
				mean_freq_m[c] = avg(sum_freq_m[c], count_m[c]);
				learned_m[c] = 1'b1;
			end
			r.anom = 0;
			r.kind = 0;
			r.warn = 0;
			r.health = sta_lta_pkg::ONE_Q16;
			trig = 1'b0;
		end else if (r.anom && !trig) begin
			// drop unconfirmed anomalies unless a critical overload
			if (!(r.warn == sta_lta_pkg::WARN_CRITICAL
					&& r.kind == sta_lta_pkg::KIND_OVERLOAD)) begin
				r.anom = 0;
				r.kind = 0;
				r.warn = 0;
			end
		end
		trig_m[c] = trig;
		r.ratio = ratio;
		r.trig = trig;
		r.b_rms = mean_rms_m[c];
		r.b_energy = mean_energy_m[c];
		r.b_freq = mean_freq_m[c];
		r.b_valid = learned_m[c];
		return r;
	endfunction

	function automatic fld_arr_t fields_of(gate_res_t r);
		fld_arr_t f;
		f = '{r.ch, r.anom, r.kind, r.warn, r.health, r.ratio, r.trig, r.calib,
			r.b_rms, r.b_energy, r.b_freq, r.b_valid};
		return f;
	endfunction

	task automatic report(string what, longint unsigned got, longint unsigned want);
		$display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// check each accepted result word and pace the receiver
	always @(posedge clk) begin
		gate_res_t got_r;
		fld_arr_t got_f, want_f;
		if (arst_n && out_valid && !out_stall) begin
			got_r = '{channel_out, anomaly_out, anomaly_kind_out, warning_out, health_out,
				sta_lta_ratio, triggered_out, calibrating, baseline_rms, baseline_energy,
				baseline_freq, baseline_valid};
			if (pend_wr == pend_rd) begin
				report("unexpected word", channel_out, 0);
			end else begin
				got_f = fields_of(got_r);
				want_f = fields_of(pending_verdicts[pend_rd % PEND_DEPTH]);
				pend_rd++;
				for (int i = 0; i < 12; i++)
					if (got_f[i] !== want_f[i])
						report(fld_name[i], got_f[i], want_f[i]);
			end
			words_checked++;
			trig_seen += triggered_out;
			learned_seen += (calibrating && baseline_valid);
		end
		if (stall_left > 0)
			stall_left--;
		else if (!quiet && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 3);
		out_stall <= (stall_left > 0);
	end

	task automatic send_word(gate_item_t it, bit typed, gate_res_t want);
		gate_res_t pr;
		int gap;
		gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		channel <= it.ch;
		rms_value <= it.rms;
		energy_value <= it.energy;
		freq_value <= it.freq;
		anomaly_in <= it.anom;
		anomaly_kind_in <= it.kind;
		warning_in <= it.warn;
		health_in <= it.health;
		do @(posedge clk); while (in_stall !== 1'b0);
		pr = gate_predict(it);
		pending_verdicts[pend_wr % PEND_DEPTH] = typed ? want : pr;
		pend_wr++;
		items_sent++;
	endtask

	// hold the sender until every result has drained and the core is idle
	task automatic drain;
		in_valid <= 1'b0;
		while (pend_wr != pend_rd)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(sta_lta_pkg::cfg_idx_t idx, bit [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			sta_lta_pkg::CFG_STA_ALPHA:
				sta_alpha_m = (d[16:0] > sta_lta_pkg::ONE_Q16) ? sta_lta_pkg::ONE_Q16 : d[16:0];
			sta_lta_pkg::CFG_LTA_ALPHA:
				lta_alpha_m = (d[16:0] > sta_lta_pkg::ONE_Q16) ? sta_lta_pkg::ONE_Q16 : d[16:0];
			sta_lta_pkg::CFG_ON_RATIO: on_m = d;
			sta_lta_pkg::CFG_OFF_RATIO: off_m = d;
			sta_lta_pkg::CFG_CALIB_WINDOWS: calib_m = d[15:0];
			default: ;
		endcase
	endtask

	task automatic set_all(bit [31:0] sa, bit [31:0] la, bit [31:0] on, bit [31:0] off,
			bit [31:0] cw);
		write_reg(sta_lta_pkg::CFG_STA_ALPHA, sa);
		write_reg(sta_lta_pkg::CFG_LTA_ALPHA, la);
		write_reg(sta_lta_pkg::CFG_ON_RATIO, on);
		write_reg(sta_lta_pkg::CFG_OFF_RATIO, off);
		write_reg(sta_lta_pkg::CFG_CALIB_WINDOWS, cw);
		cfg_valid <= 1'b0;
	endtask

	// mostly steady channels with spikes and drops; some fully random noise
	function automatic gate_item_t make_item();
		gate_item_t it;
		int pick;
		pick = $urandom_range(0, 9);
		it.energy = $urandom;
		it.freq = $urandom;
		it.anom = $urandom_range(0, 1);
		it.kind = $urandom_range(0, 7);
		it.warn = $urandom_range(0, 3);
		it.health = $urandom_range(0, 131071);
		if (pick < 8) begin
			it.ch = $urandom_range(0, 7);
			it.rms = level[it.ch] + $urandom_range(0, level[it.ch] / 8);
			if ($urandom_range(0, 7) == 0)
				it.rms = level[it.ch] * 8;
			else if ($urandom_range(0, 11) == 0)
				it.rms = 0;
		end else begin
			it.ch = $urandom_range(0, 63);
			it.rms = $urandom;
		end
		return it;
	endfunction

	stim_row_t stim_rows [23] = '{
		'{'{0, 0, 0, 0, 1, 5, 2, 17'h1FFFF}, 1,
			'{0, 0, 0, 0, 65536, 65536, 0, 1, 0, 0, 0, 0}},
		'{'{63, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 7, 3, 0}, 1,
			'{63, 0, 0, 0, 65536, 65536, 0, 1, 0, 0, 0, 0}},
		'{'{0, 0, 32'h1234, 32'h50000, 0, 0, 0, 100}, 1,
			'{0, 0, 0, 0, 65536, 65536, 0, 1, 0, 0, 0, 0}},
		'{'{5, 32'h10000, 32'h20000, 32'h320000, 0, 0, 0, 60000}, 0, '{default: 0}},
		'{'{5, 32'h10000, 32'h20000, 32'h320000, 0, 0, 0, 60000}, 0, '{default: 0}},
		'{'{5, 32'h10000, 32'h20000, 32'h320000, 0, 0, 0, 60000}, 0, '{default: 0}},
		'{'{5, 32'h10000, 32'h20000, 32'h320000, 0, 0, 0, 60000}, 0, '{default: 0}},
		'{'{5, 32'h10000, 32'h20000, 32'h320000, 0, 0, 0, 60000}, 0, '{default: 0}},
		'{'{5, 32'h10000, 32'h20000, 32'h320000, 0, 0, 0, 60000}, 0, '{default: 0}},
		'{'{5, 32'h10000, 32'h20000, 32'h320000, 0, 0, 0, 60000}, 0, '{default: 0}},
		'{'{5, 32'h10000, 32'h20000, 32'h320000, 0, 0, 0, 60000}, 0, '{default: 0}},
		'{'{5, 32'h10000, 32'h20000, 32'h320000, 0, 0, 0, 60000}, 0, '{default: 0}},
		'{'{5, 32'h10001, 32'h20001, 32'h320001, 1, 1, 1, 50000}, 0, '{default: 0}},
		'{'{5, 32'h100000, 32'h900000, 32'h10000, 1, 1, 1, 40000}, 0, '{default: 0}},
		'{'{5, 32'h100000, 32'h900000, 32'h10000, 1, 3, 2, 30000}, 0, '{default: 0}},
		'{'{5, 32'h100000, 32'h900000, 32'h10000, 1, 2, 2, 20000}, 0, '{default: 0}},
		'{'{5, 32'h100000, 32'h900000, 32'h10000, 1, 4, 1, 70000}, 0, '{default: 0}},
		'{'{5, 0, 0, 0, 0, 6, 3, 10000}, 0, '{default: 0}},
		'{'{5, 0, 0, 0, 0, 0, 0, 65536}, 0, '{default: 0}},
		'{'{5, 0, 0, 0, 1, 5, 2, 9000}, 0, '{default: 0}},
		'{'{5, 0, 0, 0, 1, 5, 1, 8000}, 0, '{default: 0}},
		'{'{5, 0, 0, 0, 1, 7, 3, 17'h10001}, 0, '{default: 0}},
		'{'{5, 32'h10000, 0, 0, 0, 0, 0, 65535}, 0, '{default: 0}}
	};

	initial begin
		gate_res_t none;
		none = '{default: 0};
		arst_n = 1'b0;
		in_valid = 1'b0;
		channel = '0;
		rms_value = '0;
		energy_value = '0;
		freq_value = '0;
		anomaly_in = 1'b0;
		anomaly_kind_in = '0;
		warning_in = '0;
		health_in = '0;
		cfg_valid = 1'b0;
		cfg_index = sta_lta_pkg::CFG_STA_ALPHA;
		cfg_data = '0;
		sta_alpha_m = 17'd6554;
		lta_alpha_m = 17'd655;
		on_m = 32'd196608;
		off_m = 32'd98304;
		calib_m = 16'd10;
		for (int i = 0; i < 8; i++)
			level[i] = 32'h4000 << (i % 4);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset state, field extremes, calibration, gating cases
		foreach (stim_rows[i])
			send_word(stim_rows[i].it, stim_rows[i].typed, stim_rows[i].want);

		// random phases, each under its own register settings
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				0: set_all(6554, 655, 196608, 98304, 4);
				1: set_all(65536, 0, 0, 32'hFFFFFFFF, 1);
				2: set_all(131071, 131071, 32'hFFFFFFFF, 0, 0);
				3: set_all(0, 1, 65536, 65535, 65535);
				4: set_all($urandom_range(0, 65536), $urandom_range(0, 65536),
					$urandom_range(65536, 400000), $urandom_range(0, 65536),
					$urandom_range(1, 6));
				default: set_all(20000, 300, 131072, 80000, 3);
			endcase
			quiet = (ph == 5);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_word(make_item(), 1'b0, none);
		end

		in_valid <= 1'b0;
		while (pend_wr != pend_rd)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		$display("Sent %0d windows, checked %0d results over six register settings.",
			items_sent, words_checked);
		$display("Triggered results: %0d, calibrations completed: %0d.",
			trig_seen, learned_seen);
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// end the run if the block hangs
	initial begin
		#20ms;
		$display("Timeout with %0d results outstanding", pend_wr - pend_rd);
		$display("tb NOT OK");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/sta_lta_pkg.sv
rtl/sta_lta_div.sv
rtl/sta_lta_onset_gate.sv
tb/tb.sv
